FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the button classifier.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked property that also holds across reset
`define ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

FILE: rtl/core/bpc_pkg.sv
// Package for the button press classifier: sizes, codes and shared types.
// No dependencies; imported by every other file of the block but assert_macros.svh.
package bpc_pkg;

    // Sizing
    localparam int NUM_BUTTONS = 8;
    localparam int COUNT_BITS  = 16;
    localparam int BTN_BITS    = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    // Field widths
    localparam int OP_BITS    = 2;
    localparam int IDX_BITS   = 8;
    localparam int STATE_BITS = 2;
    localparam int TICK_BITS  = 16;
    localparam int CMP_BITS   = (COUNT_BITS > TICK_BITS) ? COUNT_BITS : TICK_BITS;

    // Configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SHORT_TICKS   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_TICKS    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PRESSED_LEVEL = 2'd2;

    // Operation codes
    localparam logic [OP_BITS-1:0] OP_SAMPLE     = 2'd0;
    localparam logic [OP_BITS-1:0] OP_READ_LEVEL = 2'd1;
    localparam logic [OP_BITS-1:0] OP_READ_EDGE  = 2'd2;
    localparam logic [OP_BITS-1:0] OP_READ_FAST  = 2'd3;

    // Button state codes
    localparam logic [STATE_BITS-1:0] ST_RELEASED = 2'd0;
    localparam logic [STATE_BITS-1:0] ST_SHORT    = 2'd1;
    localparam logic [STATE_BITS-1:0] ST_LONG     = 2'd2;
    localparam logic [STATE_BITS-1:0] ST_FAULT    = 2'd3;

    // Effective configuration seen by the classifier
    typedef struct packed {
        logic [TICK_BITS-1:0] short_thr;
        logic [TICK_BITS-1:0] long_thr;
        logic                 pressed_level;
    } cfg_t;

    typedef struct packed {
        logic [OP_BITS-1:0]  operation;
        logic [IDX_BITS-1:0] button_index;
        logic                pin_level;
    } item_t;

    typedef struct packed {
        logic [STATE_BITS-1:0] state_value;
        logic                  press_event;
    } result_t;

endpackage

FILE: rtl/core/bpc_in_if.sv
// Input channel of the button classifier: valid/ready plus one item.
// Depends on bpc_pkg.
interface bpc_in_if import bpc_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [OP_BITS-1:0]  operation;
    logic [IDX_BITS-1:0] button_index;
    logic                pin_level;

    modport source (output valid, output operation, output button_index,
                    output pin_level, input ready);
    modport sink   (input valid, input operation, input button_index,
                    input pin_level, output ready);

endinterface

FILE: rtl/core/bpc_out_if.sv
// Result channel of the button classifier: valid/ready plus one result.
// Depends on bpc_pkg.
interface bpc_out_if import bpc_pkg::*; ();

    logic                  valid;
    logic                  ready;
    logic [STATE_BITS-1:0] state_value;
    logic                  press_event;

    modport source (output valid, output state_value, output press_event,
                    input ready);
    modport sink   (input valid, input state_value, input press_event,
                    output ready);

endinterface

FILE: rtl/core/bpc_cfg_regs.sv
// Configuration registers and derived thresholds of the button classifier.
// Depends on bpc_pkg.
module bpc_cfg_regs import bpc_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [CFG_IDX_BITS-1:0]  wr_index,
    input  logic [CFG_DATA_BITS-1:0] wr_data,
    output cfg_t                     cfg
);

    logic [TICK_BITS-1:0] short_ticks_reg;
    logic [TICK_BITS-1:0] long_ticks_reg;
    logic                 pressed_level_reg;
    logic [TICK_BITS-1:0] short_thr;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_ticks_reg   <= TICK_BITS'(5);
            long_ticks_reg    <= TICK_BITS'(100);
            pressed_level_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_SHORT_TICKS:   short_ticks_reg   <= wr_data[TICK_BITS-1:0];
                CFG_LONG_TICKS:    long_ticks_reg    <= wr_data[TICK_BITS-1:0];
                CFG_PRESSED_LEVEL: pressed_level_reg <= wr_data[0];
                default:           ;
            endcase
        end
    end

    // Zero short threshold acts as one; long threshold never below short
    always_comb
    begin
        short_thr = (short_ticks_reg == '0) ? TICK_BITS'(1) : short_ticks_reg;
        cfg.short_thr     = short_thr;
        cfg.long_thr      = (long_ticks_reg < short_thr) ? short_thr : long_ticks_reg;
        cfg.pressed_level = pressed_level_reg;
    end

endmodule

FILE: rtl/core/bpc_button_state.sv
// Per-button state table and the single-pass update for one transaction.
// Depends on bpc_pkg.
module bpc_button_state import bpc_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    logic [STATE_BITS-1:0] level_reg   [NUM_BUTTONS];
    logic [STATE_BITS-1:0] edge_reg    [NUM_BUTTONS];
    logic [STATE_BITS-1:0] fast_reg    [NUM_BUTTONS];
    logic                  armed_reg   [NUM_BUTTONS];
    logic [COUNT_BITS-1:0] short_cnt_reg [NUM_BUTTONS];
    logic [COUNT_BITS-1:0] long_cnt_reg  [NUM_BUTTONS];
    logic                  timeout_reg [NUM_BUTTONS];

    logic [STATE_BITS-1:0] level_next;
    logic [STATE_BITS-1:0] edge_next;
    logic [STATE_BITS-1:0] fast_next;
    logic                  armed_next;
    logic [COUNT_BITS-1:0] short_cnt_next;
    logic [COUNT_BITS-1:0] long_cnt_next;
    logic                  timeout_next;

    logic                  idx_ok;
    logic [BTN_BITS-1:0]   btn;
    logic                  pressed;
    logic [COUNT_BITS-1:0] short_inc;
    logic [COUNT_BITS-1:0] long_inc;

    assign idx_ok  = (item.button_index < IDX_BITS'(NUM_BUTTONS));
    assign btn     = item.button_index[BTN_BITS-1:0];
    assign pressed = (item.pin_level == cfg.pressed_level);

    // Saturating increments of the selected counters
    assign short_inc = (short_cnt_reg[btn] == '1) ? short_cnt_reg[btn]
                                                  : short_cnt_reg[btn] + 1'b1;
    assign long_inc  = (long_cnt_reg[btn] == '1) ? long_cnt_reg[btn]
                                                 : long_cnt_reg[btn] + 1'b1;

    // Next state of the addressed button and the result
    always_comb
    begin
        level_next     = level_reg[btn];
        edge_next      = edge_reg[btn];
        fast_next      = fast_reg[btn];
        armed_next     = armed_reg[btn];
        short_cnt_next = short_cnt_reg[btn];
        long_cnt_next  = long_cnt_reg[btn];
        timeout_next   = timeout_reg[btn];
        res.state_value = ST_RELEASED;
        res.press_event = 1'b0;

        if (item.operation == OP_SAMPLE)
        begin
            if (idx_ok && !pressed)
            begin
                level_next     = ST_RELEASED;
                fast_next      = ST_RELEASED;
                armed_next     = 1'b1;
                short_cnt_next = '0;
                long_cnt_next  = '0;
            end
            else if (idx_ok)
            begin
                short_cnt_next = short_inc;
                long_cnt_next  = long_inc;
                case (level_reg[btn])
                    ST_RELEASED:
                    begin
                        if (CMP_BITS'(short_inc) >= CMP_BITS'(cfg.short_thr))
                        begin
                            level_next      = ST_SHORT;
                            fast_next       = ST_SHORT;
                            if (armed_reg[btn])
                                edge_next   = ST_SHORT;
                            res.press_event = 1'b1;
                            short_cnt_next  = '0;
                            timeout_next    = 1'b1;
                        end
                    end
                    ST_SHORT:
                    begin
                        armed_next = 1'b1;
                        if (CMP_BITS'(long_inc) >= CMP_BITS'(cfg.long_thr))
                        begin
                            level_next    = ST_LONG;
                            long_cnt_next = '0;
                        end
                        fast_next      = ST_RELEASED;
                        short_cnt_next = '0;
                        timeout_next   = 1'b0;
                    end
                    ST_LONG:
                    begin
                        fast_next = timeout_reg[btn] ? ST_RELEASED : ST_LONG;
                        if (armed_reg[btn])
                            edge_next = ST_LONG;
                        timeout_next = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
        else if (!idx_ok)
        begin
            res.state_value = ST_FAULT;
        end
        else
        begin
            case (item.operation)
                OP_READ_LEVEL: res.state_value = level_reg[btn];
                OP_READ_EDGE:  res.state_value = edge_reg[btn];
                default:       res.state_value = fast_reg[btn];
            endcase
            // level and edge reads consume the latched edge
            if (item.operation != OP_READ_FAST)
            begin
                edge_next  = ST_RELEASED;
                armed_next = 1'b0;
            end
        end
    end

    // Write back the addressed entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                level_reg[i]     <= ST_RELEASED;
                edge_reg[i]      <= ST_RELEASED;
                fast_reg[i]      <= ST_RELEASED;
                armed_reg[i]     <= 1'b0;
                short_cnt_reg[i] <= '0;
                long_cnt_reg[i]  <= '0;
                timeout_reg[i]   <= 1'b0;
            end
        end
        else if (en && idx_ok)
        begin
            level_reg[btn]     <= level_next;
            edge_reg[btn]      <= edge_next;
            fast_reg[btn]      <= fast_next;
            armed_reg[btn]     <= armed_next;
            short_cnt_reg[btn] <= short_cnt_next;
            long_cnt_reg[btn]  <= long_cnt_next;
            timeout_reg[btn]   <= timeout_next;
        end
    end

endmodule

FILE: rtl/core/button_press_classifier_unit.sv
// Top level of the button press classifier: input register, state update, result register.
// Depends on bpc_pkg, bpc_in_if, bpc_out_if, bpc_cfg_regs, bpc_button_state.
//
//   channel   | role             | payload
//   ----------+------------------+----------------------------------------------
//   item      | sink, valid/ready| operation, button_index, pin_level
//   result    | source, valid/rdy| state_value, press_event
//   cfg       | write only       | cfg_wr_en, cfg_index, cfg_data
//
// One transaction per cycle unless results stall; items pass input, then result register.
// The button state is read and written back in the cycle between the two registers,
// so consecutive transactions on the same button see each other's updates.
// Reset clears the state of every button and both valid flags at once; no sweep.
// A stalled result holds in the result register while the input register takes one more.
module button_press_classifier_unit import bpc_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    bpc_in_if.sink                   item,
    bpc_out_if.source                result,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    logic    in_valid_next;
    result_t result_reg;
    result_t result_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    out_free;
    logic    fire;
    logic    take;

    // Configuration
    bpc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_wr_en),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Handshake control
    assign out_free   = !out_valid_reg || result.ready;
    assign fire       = in_valid_reg && out_free;
    assign item.ready = !in_valid_reg || out_free;
    assign take       = item.valid && item.ready;

    assign in_valid_next  = take ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = fire ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.operation    <= item.operation;
            item_reg.button_index <= item.button_index;
            item_reg.pin_level    <= item.pin_level;
        end
    end

    // Button state update
    bpc_button_state u_state (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (fire),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (result_next)
    );

    // Result register
    always_ff @(posedge clk)
    begin
        if (fire)
            result_reg <= result_next;
    end

    assign result.valid       = out_valid_reg;
    assign result.state_value = result_reg.state_value;
    assign result.press_event = result_reg.press_event;

endmodule

FILE: rtl/core/bpc_checker.sv
// Port-level checks for the button press classifier, bound to the top level.
// Depends on bpc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bpc_checker import bpc_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [STATE_BITS-1:0] state_value,
    input logic                  press_event
);

    // No result may be pending in the first cycle after reset
    `ASSERT_CLK(a_no_result_after_reset, clk, rst_n, $rose(rst_n) |-> !out_valid, "result valid straight after reset")

    // With the result register empty, the input side must never stall
    `ASSERT_CLK(a_ready_when_empty, clk, rst_n, !out_valid |-> in_ready, "input stalled with no result pending")

    // A press event only comes from a sample tick, whose state field is zero
    `ASSERT_CLK(a_event_state_zero, clk, rst_n, (out_valid && press_event) |-> (state_value == ST_RELEASED), "press event with non-zero state")

    // A stalled result stays offered and unchanged
    `ASSERT_CLK(a_result_held, clk, rst_n, (out_valid && !out_ready) |=> out_valid, "result withdrawn while stalled")
    `ASSERT_CLK(a_result_stable, clk, rst_n, (out_valid && !out_ready) |=> ($stable(state_value) && $stable(press_event)), "result changed while stalled")

endmodule

bind button_press_classifier_unit bpc_checker u_bpc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (item.valid),
    .in_ready    (item.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .state_value (result.state_value),
    .press_event (result.press_event)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for button_press_classifier_unit: a clocked driver
// and monitor around the RTL channel interfaces, with a transaction-level predictor.
// Depends on bpc_pkg, bpc_in_if, bpc_out_if and the RTL top level.
module tb_top;
    import bpc_pkg::*;

    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          LONG_HOLD      = 300;
    localparam int          DRAIN_CYCLES   = 16;
    localparam int          PHASE_OPS      = 170;
    localparam int unsigned COUNT_MAX      = int'((64'd1 << COUNT_BITS) - 1);

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Configuration port, idle from time zero
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    // Channel drive registers
    logic  in_valid  = 1'b0;
    item_t in_item   = '0;
    logic  out_ready = 1'b0;

    bpc_in_if  item_if ();
    bpc_out_if result_if ();

    assign item_if.valid        = in_valid;
    assign item_if.operation    = in_item.operation;
    assign item_if.button_index = in_item.button_index;
    assign item_if.pin_level    = in_item.pin_level;
    assign result_if.ready      = out_ready;

    button_press_classifier_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_if),
        .result    (result_if),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // Mirror of the configuration registers
    logic [TICK_BITS-1:0] short_thr   = 16'd5;
    logic [TICK_BITS-1:0] long_thr    = 16'd100;
    logic                 pressed_lvl = 1'b0;

    // Mirror of the per-button state
    logic [STATE_BITS-1:0] lvl_st    [NUM_BUTTONS];
    logic [STATE_BITS-1:0] edge_st   [NUM_BUTTONS];
    logic [STATE_BITS-1:0] fast_st   [NUM_BUTTONS];
    bit                    armed     [NUM_BUTTONS];
    int unsigned           short_cnt [NUM_BUTTONS];
    int unsigned           long_cnt  [NUM_BUTTONS];
    bit                    pulse_done[NUM_BUTTONS];

    item_t   queued_ops[$];
    result_t predicted_results[$];
    int      queued_count = 0;
    int      fail_count   = 0;

    // Work out the result of one accepted item and advance the button state
    function automatic result_t predict_press(item_t it);
        result_t     res;
        int unsigned sthr;
        int unsigned lthr;
        int unsigned b;
        res  = '0;
        sthr = (short_thr == 0) ? 1 : short_thr;
        lthr = (long_thr < sthr) ? sthr : long_thr;
        b    = it.button_index;
        if (it.operation == OP_SAMPLE) begin
            // bad index on a sample tick is dropped
            if (b < NUM_BUTTONS) begin
                if (it.pin_level != pressed_lvl) begin
                    lvl_st[b]    = ST_RELEASED;
                    fast_st[b]   = ST_RELEASED;
                    armed[b]     = 1'b1;
                    short_cnt[b] = 0;
                    long_cnt[b]  = 0;
                end
                else begin
                    if (short_cnt[b] < COUNT_MAX) short_cnt[b]++;
                    if (long_cnt[b] < COUNT_MAX) long_cnt[b]++;
                    case (lvl_st[b])
                        ST_RELEASED:
                        begin
                            if (short_cnt[b] >= sthr) begin
                                lvl_st[b]  = ST_SHORT;
                                fast_st[b] = ST_SHORT;
                                if (armed[b]) edge_st[b] = ST_SHORT;
                                res.press_event = 1'b1;
                                short_cnt[b]  = 0;
                                pulse_done[b] = 1'b1;
                            end
                        end
                        ST_SHORT:
                        begin
                            armed[b] = 1'b1;
                            if (long_cnt[b] >= lthr) begin
                                lvl_st[b]   = ST_LONG;
                                long_cnt[b] = 0;
                            end
                            fast_st[b]    = ST_RELEASED;
                            short_cnt[b]  = 0;
                            pulse_done[b] = 1'b0;
                        end
                        ST_LONG:
                        begin
                            fast_st[b] = pulse_done[b] ? ST_RELEASED : ST_LONG;
                            if (armed[b]) edge_st[b] = ST_LONG;
                            pulse_done[b] = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
        end
        else if (b >= NUM_BUTTONS) begin
            res.state_value = ST_FAULT;
        end
        else begin
            case (it.operation)
                OP_READ_LEVEL: res.state_value = lvl_st[b];
                OP_READ_EDGE:  res.state_value = edge_st[b];
                default:       res.state_value = fast_st[b];
            endcase
            // level and edge reads consume the latched edge
            if (it.operation != OP_READ_FAST) begin
                edge_st[b] = ST_RELEASED;
                armed[b]   = 1'b0;
            end
        end
        return res;
    endfunction

    // Driver: bursts of transactions with random gaps between them
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid   <= 1'b0;
            in_item    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else begin
            if (in_valid && item_if.ready)
                predicted_results.push_back(predict_press(in_item));
            if (!in_valid || item_if.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (queued_ops.size() != 0) begin
                    in_item  <= queued_ops.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end
                    else begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                                 : $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: a randomly chosen stall pattern that is changed periodically, plus a periodic long hold-off
    int unsigned rx_cycle;
    int          hold_left;
    int          rx_mode;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            rx_cycle  <= 0;
            hold_left <= 0;
            rx_mode   <= 0;
        end
        else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 128 == 0) rx_mode <= $urandom_range(0, 3);
            if (rx_cycle % 2048 == 1000) begin
                hold_left <= LONG_HOLD;
                out_ready <= 1'b0;
            end
            else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else begin
                case (rx_mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= (rx_cycle[1:0] == 2'd0);
                    default: out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Monitor: compare each result transaction with the oldest prediction
    always @(posedge clk) begin
        result_t exp_res;
        if (rst_n && result_if.valid && out_ready) begin
            if (predicted_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: state %0d event %0d",
                             result_if.state_value, result_if.press_event);
            end
            else begin
                exp_res = predicted_results.pop_front();
                if (exp_res.state_value !== result_if.state_value ||
                    exp_res.press_event !== result_if.press_event) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: expected state %0d event %0d, got state %0d event %0d",
                                 exp_res.state_value, exp_res.press_event,
                                 result_if.state_value, result_if.press_event);
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel
    int idle_cycles = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && item_if.ready) || (result_if.valid && out_ready)) begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", idle_cycles);
                $display("Simulation FAILED");
                $finish;
            end
            else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic queue_item(input logic [OP_BITS-1:0] op, input int idx, input logic pin);
        item_t it;
        it.operation    = op;
        it.button_index = idx[IDX_BITS-1:0];
        it.pin_level    = pin;
        queued_ops.push_back(it);
        queued_count++;
    endtask

    task automatic wait_idle();
        while (queued_ops.size() != 0 || in_valid || predicted_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_SHORT_TICKS:   short_thr   = data;
            CFG_LONG_TICKS:    long_thr    = data;
            CFG_PRESSED_LEVEL: pressed_lvl = data[0];
            default: ;
        endcase
    endtask

    // New thresholds and pressed level; upper bits of the level write are junk
    task automatic set_config(input int sthr, input int lthr, input logic lvl);
        logic [CFG_DATA_BITS-1:0] lvl_word;
        lvl_word    = CFG_DATA_BITS'($urandom_range(0, 65535));
        lvl_word[0] = lvl;
        wait_idle();
        write_cfg(CFG_SHORT_TICKS, sthr[CFG_DATA_BITS-1:0]);
        write_cfg(CFG_LONG_TICKS, lthr[CFG_DATA_BITS-1:0]);
        write_cfg(CFG_PRESSED_LEVEL, lvl_word);
    endtask

    // One press of a button: optional release to arm, pressed ticks with reads
    // and other buttons mixed in, then a read and usually a release
    task automatic press_sequence();
        int                 b;
        int                 span;
        int                 ticks;
        int unsigned        sthr;
        int unsigned        lthr;
        logic [OP_BITS-1:0] rd_op;
        b     = $urandom_range(0, NUM_BUTTONS - 1);
        sthr  = (short_thr == 0) ? 1 : short_thr;
        lthr  = (long_thr < sthr) ? sthr : long_thr;
        span  = (lthr + 4 > 40) ? 40 : int'(lthr) + 4;
        ticks = $urandom_range(0, span);
        if ($urandom_range(0, 3) != 0) queue_item(OP_SAMPLE, b, !pressed_lvl);
        for (int t = 0; t < ticks; t++) begin
            queue_item(OP_SAMPLE, b, pressed_lvl);
            if ($urandom_range(0, 4) == 0) begin
                rd_op = OP_BITS'($urandom_range(OP_READ_LEVEL, OP_READ_FAST));
                queue_item(rd_op, b, 1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 9) == 0)
                queue_item(OP_SAMPLE, $urandom_range(0, NUM_BUTTONS - 1),
                           1'($urandom_range(0, 1)));
        end
        rd_op = OP_BITS'($urandom_range(OP_READ_LEVEL, OP_READ_FAST));
        queue_item(rd_op, b, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 3) != 0) queue_item(OP_SAMPLE, b, !pressed_lvl);
    endtask

    task automatic random_phase(input int n_ops);
        int                 target;
        logic [OP_BITS-1:0] op;
        int                 idx;
        target = queued_count + n_ops;
        while (queued_count < target) begin
            if ($urandom_range(0, 4) != 0) begin
                press_sequence();
            end
            else begin
                op  = OP_BITS'($urandom_range(OP_SAMPLE, OP_READ_FAST));
                idx = ($urandom_range(0, 1) == 0) ? $urandom_range(0, NUM_BUTTONS - 1)
                                                  : $urandom_range(0, 255);
                queue_item(op, idx, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Main sequence: reset, directed checks, then random phases across settings
    initial begin
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            lvl_st[b]     = ST_RELEASED;
            edge_st[b]    = ST_RELEASED;
            fast_st[b]    = ST_RELEASED;
            armed[b]      = 1'b0;
            short_cnt[b]  = 0;
            long_cnt[b]   = 0;
            pulse_done[b] = 1'b0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reads on an untouched button, then bad indexes on every operation
        queue_item(OP_READ_LEVEL, 0, 1'b0);
        queue_item(OP_READ_EDGE, 0, 1'b1);
        queue_item(OP_READ_FAST, 0, 1'b0);
        queue_item(OP_READ_LEVEL, NUM_BUTTONS, 1'b1);
        queue_item(OP_READ_EDGE, 255, 1'b0);
        queue_item(OP_READ_FAST, 128, 1'b1);
        queue_item(OP_SAMPLE, 255, 1'b0);
        queue_item(OP_SAMPLE, NUM_BUTTONS, 1'b1);
        // button 7: release arms the edge, five pressed ticks give a short press
        queue_item(OP_SAMPLE, 7, 1'b1);
        repeat (5) queue_item(OP_SAMPLE, 7, 1'b0);
        // fast-edge read has no side effect, edge read clears the edge
        queue_item(OP_READ_FAST, 7, 1'b0);
        queue_item(OP_READ_FAST, 7, 1'b1);
        queue_item(OP_READ_EDGE, 7, 1'b0);
        queue_item(OP_READ_EDGE, 7, 1'b1);
        queue_item(OP_READ_LEVEL, 7, 1'b0);
        queue_item(OP_SAMPLE, 7, 1'b0);
        queue_item(OP_READ_FAST, 7, 1'b0);
        // button 0 was never armed, so its edge stays released
        repeat (5) queue_item(OP_SAMPLE, 0, 1'b0);
        queue_item(OP_READ_EDGE, 0, 1'b0);

        // ordinary thresholds, then zero short and long below short, then long below a larger short
        set_config(2, 6, 1'b1);
        random_phase(PHASE_OPS);
        set_config(0, 0, 1'b0);
        random_phase(PHASE_OPS);
        set_config(4, 3, 1'b1);
        random_phase(PHASE_OPS);
        set_config(1, 65535, 1'b0);
        random_phase(PHASE_OPS);
        repeat (3) begin
            set_config($urandom_range(0, 8), $urandom_range(0, 25),
                       1'($urandom_range(0, 1)));
            random_phase(PHASE_OPS);
        end

        // both thresholds at their maximum: a held button stays released
        set_config(65535, 65535, 1'b1);
        queue_item(OP_SAMPLE, 5, 1'b0);
        for (int t = 1; t <= 20; t++) begin
            queue_item(OP_SAMPLE, 5, 1'b1);
            if (t % 5 == 0) queue_item(OP_READ_FAST, 5, 1'b0);
        end
        queue_item(OP_READ_LEVEL, 5, 1'b0);
        queue_item(OP_READ_EDGE, 5, 1'b0);
        queue_item(OP_SAMPLE, 5, 1'b0);
        random_phase(100);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && predicted_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: button_press_classifier_unit.f
+incdir+rtl/core
rtl/core/bpc_pkg.sv
rtl/core/bpc_in_if.sv
rtl/core/bpc_out_if.sv
rtl/core/bpc_cfg_regs.sv
rtl/core/bpc_button_state.sv
rtl/core/button_press_classifier_unit.sv
rtl/core/bpc_checker.sv
tb/sv/tb_top.sv
